FILE: sv/particle_gravity_fade_update_unit_assert.svh
// Assertion macros for the particle update unit.
// Each macro expects clk and arst_n in scope.
`ifndef PARTICLE_GRAVITY_FADE_UPDATE_UNIT_ASSERT_SVH
`define PARTICLE_GRAVITY_FADE_UPDATE_UNIT_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define PGFU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define PGFU_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: sv/pgfu_pkg.sv
// ----------------------------------------------------------------------------
// pgfu_pkg
// Constants, types and helpers for the particle gravity/fade update unit.
// ----------------------------------------------------------------------------
package pgfu_pkg;

	// gravity register reset: 25.5 in Q16.16
	localparam logic [31:0] GRAVITY_RESET = 32'd1671168;
	// 0.1 and 1.0 in Q16.16
	localparam logic signed [35:0] TENTH_Q16 = 36'sd6554;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	// pi/2 with 30 fraction bits
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	// default sine table resolution
	localparam int SINE_TABLE_BITS_DEF = 10;
	// quotient bits of the lifetime ratio below one
	localparam int DIV_STEPS = 16;
	// Taylor terms after the first
	localparam int SINE_TERMS = 10;

	// finished fields carried down the pipe behind the divider
	typedef struct packed {
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic signed [31:0] nz;
		logic signed [31:0] nvy;
		logic signed [31:0] nlife;
		logic               neg;
		logic               skip;
		logic [16:0]        astart;
		logic [30:0]        sstart;
	} pgfu_pass_t;

	// saturate a widened signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -36'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

FILE: sv/particle_gravity_fade_update_unit.sv
// ----------------------------------------------------------------------------
// particle_gravity_fade_update_unit
// Euler step of one particle under gravity with a lifetime-driven fade.
// ----------------------------------------------------------------------------
// One particle word enters per clock while the output side keeps taking
// words; a stalled stage holds its word and bubbles ahead of it still fill.
// The pipeline is built around the 16-stage restoring divider for the
// life ratio, framed by three motion stages in front and sine lookup,
// scaling and output stages behind it. The sine is read from a ROM of
// 2^SINE_TABLE_BITS+1 entries with a registered read.
// The gravity register may be written only while no word is in flight.
module particle_gravity_fade_update_unit #(
	parameter int SINE_TABLE_BITS = pgfu_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// gravity register write
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data,
	// particle in
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        time_step,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	input  logic signed [31:0] life_left,
	input  logic [30:0]        life_total,
	input  logic [16:0]        alpha_start,
	input  logic [30:0]        size_start,
	// particle out
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_pos_z,
	output logic signed [31:0] new_vel_y,
	output logic signed [31:0] new_life_left,
	output logic signed [17:0] new_alpha,
	output logic signed [31:0] new_size,
	output logic               skipped
);
	import pgfu_pkg::*;

	localparam int SINE_DEPTH = (1 << SINE_TABLE_BITS) + 1;
	localparam int ST_DIV0 = 3;
	localparam int ST_ROM = ST_DIV0 + DIV_STEPS;
	localparam int ST_MUL = ST_ROM + 1;
	localparam int ST_OUT = ST_MUL + 1;
	localparam int NST = ST_OUT + 1;

	typedef logic [16:0] sine_rom_t [SINE_DEPTH];

	// shift-subtract quotient, used only while building the table
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], num[b]};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// quarter-wave sine table, Q16, built at elaboration
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] dv;
		longint      sum;
		longint      r;
		for (int k = 0; k < SINE_DEPTH; k++) begin
			x = (64'(k) * PI_HALF_Q30 + (64'd1 << (SINE_TABLE_BITS - 1))) >> SINE_TABLE_BITS;
			x2 = (x * x + (64'd1 << 29)) >> 30;
			term = x;
			sum = longint'(x);
			for (int n = 1; n <= SINE_TERMS; n++) begin
				dv = 64'((2 * n) * (2 * n + 1));
				term = (term * x2 + (64'd1 << 29)) >> 30;
				term = udiv64(term, dv);
				if (n[0]) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			r = (sum + (64'sd1 <<< 13)) >>> 14;
			if (r > 65536) begin
				r = 65536;
			end
			rom[k] = 17'(r);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	// gravity register
	logic [31:0] grav_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= GRAVITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			grav_q <= cfg_data;
		end
	end

	// stage valids and per-stage advance; a stage moves if empty or if the next moves
	logic [NST-1:0] vld_q;
	logic [NST-1:0] en;
	always_comb begin
		en[NST-1] = !vld_q[NST-1] || out_ready;
		for (int i = NST - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end
	assign in_ready = en[0];
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// ---- stage 1: velocity and gravity products, life update
	logic signed [48:0] vxdt_s1, vydt_s1, vzdt_s1;
	logic [47:0]        gdt_s1;
	logic [31:0]        dt2_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1, vy_s1, nlife_s1;
	logic               skip_s1;
	logic [30:0]        total_s1, sstart_s1;
	logic [16:0]        astart_s1;
	logic signed [16:0] dt_ext;
	logic signed [35:0] life_diff;

	assign dt_ext = signed'({1'b0, time_step});
	assign life_diff = 36'(life_left) - 36'(dt_ext);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			vxdt_s1 <= vel_x * dt_ext;
			vydt_s1 <= vel_y * dt_ext;
			vzdt_s1 <= vel_z * dt_ext;
			gdt_s1 <= grav_q * time_step;
			dt2_s1 <= time_step * time_step;
			px_s1 <= pos_x;
			py_s1 <= pos_y;
			pz_s1 <= pos_z;
			vy_s1 <= vel_y;
			skip_s1 <= life_left[31];
			nlife_s1 <= life_left[31] ? life_left : sat32(life_diff);
			total_s1 <= life_total;
			astart_s1 <= alpha_start;
			sstart_s1 <= size_start;
		end
	end

	// ---- stage 2: rounded motion terms, x/z/vy done, dt^2*g product
	function automatic logic signed [33:0] rnd16_49(input logic signed [48:0] v);
		logic signed [49:0] t;
		t = 50'(v) + 50'sd32768;
		return t[49:16];
	endfunction

	logic signed [31:0] nx_s2, nz_s2, nvy_s2, py_s2, vy_s2, nlife_s2;
	logic signed [34:0] ypart_s2;
	logic [63:0]        gp_s2;
	logic               skip_s2, neg_s2;
	logic [31:0]        mag_s2;
	logic [30:0]        total_s2, sstart_s2;
	logic [16:0]        astart_s2;
	logic [32:0]        gdt_rnd;

	assign gdt_rnd = 33'((49'(gdt_s1) + 49'd32768) >> 16);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			nx_s2 <= skip_s1 ? px_s1 : sat32(36'(px_s1) + 36'(rnd16_49(vxdt_s1)));
			nz_s2 <= skip_s1 ? pz_s1 : sat32(36'(pz_s1) + 36'(rnd16_49(vzdt_s1)));
			nvy_s2 <= skip_s1 ? vy_s1 : sat32(36'(vy_s1) - signed'({3'b000, gdt_rnd}));
			ypart_s2 <= 35'(py_s1) + 35'(rnd16_49(vydt_s1));
			gp_s2 <= dt2_s1 * grav_q;
			py_s2 <= py_s1;
			vy_s2 <= vy_s1;
			skip_s2 <= skip_s1;
			nlife_s2 <= nlife_s1;
			neg_s2 <= nlife_s1[31];
			mag_s2 <= nlife_s1[31] ? 32'(-nlife_s1) : 32'(nlife_s1);
			total_s2 <= total_s1;
			astart_s2 <= astart_s1;
			sstart_s2 <= sstart_s1;
		end
	end

	// ---- stage 3: vertical position done, divider set up
	pgfu_pass_t  pass_sd  [DIV_STEPS+1];
	logic [30:0] rem_sd   [DIV_STEPS+1];
	logic [30:0] total_sd [DIV_STEPS+1];
	logic [15:0] quo_sd   [DIV_STEPS+1];
	logic        full_sd  [DIV_STEPS+1];

	logic [31:0] grav_rnd;
	logic        full_s2;
	assign grav_rnd = 32'((65'(gp_s2) + 65'h1_0000_0000) >> 33);
	// ratio saturates once |life| reaches the total; a zero life gives zero
	assign full_s2 = (mag_s2 >= {1'b0, total_s2}) && (mag_s2 != 32'd0);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			pass_sd[0].nx <= nx_s2;
			pass_sd[0].ny <= skip_s2 ? py_s2 : sat32(36'(ypart_s2) - signed'({4'b0000, grav_rnd}));
			pass_sd[0].nz <= nz_s2;
			pass_sd[0].nvy <= skip_s2 ? vy_s2 : nvy_s2;
			pass_sd[0].nlife <= nlife_s2;
			pass_sd[0].neg <= neg_s2;
			pass_sd[0].skip <= skip_s2;
			pass_sd[0].astart <= astart_s2;
			pass_sd[0].sstart <= sstart_s2;
			rem_sd[0] <= full_s2 ? 31'd0 : mag_s2[30:0];
			// zero total with zero life: divide by all ones so the quotient stays zero
			total_sd[0] <= (total_s2 == 31'd0) ? '1 : total_s2;
			quo_sd[0] <= '0;
			full_sd[0] <= full_s2;
		end
	end

	// ---- divider: one restoring quotient bit per stage
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [31:0] shl;
		logic [31:0] tot;
		logic        ge;
		logic [31:0] diff;
		assign shl = {rem_sd[j], 1'b0};
		assign tot = {1'b0, total_sd[j]};
		assign ge = shl >= tot;
		assign diff = shl - tot;
		always_ff @(posedge clk) begin
			if (en[ST_DIV0 + j]) begin
				pass_sd[j+1] <= pass_sd[j];
				rem_sd[j+1] <= ge ? diff[30:0] : shl[30:0];
				total_sd[j+1] <= total_sd[j];
				quo_sd[j+1] <= {quo_sd[j][14:0], ge};
				full_sd[j+1] <= full_sd[j];
			end
		end
	end

	// ---- sine ROM read
	logic [16:0]                  ratio;
	logic [16+SINE_TABLE_BITS:0]  idx_sum;
	logic [SINE_TABLE_BITS:0]     idx;
	logic [16:0]                  sine_s19;
	pgfu_pass_t                   pass_s19;

	assign ratio = full_sd[DIV_STEPS] ? ONE_Q16 : {1'b0, quo_sd[DIV_STEPS]};
	assign idx_sum = {ratio, {SINE_TABLE_BITS{1'b0}}} + (17 + SINE_TABLE_BITS)'(32768);
	assign idx = idx_sum[16+SINE_TABLE_BITS:16];

	always_ff @(posedge clk) begin
		if (en[ST_ROM]) begin
			sine_s19 <= SINE_ROM[idx];
			pass_s19 <= pass_sd[DIV_STEPS];
		end
	end

	// ---- signed sine times start alpha and start size
	logic signed [17:0] sine_sg;
	logic signed [35:0] aprod_s20;
	logic signed [49:0] sprod_s20;
	pgfu_pass_t         pass_s20;

	assign sine_sg = pass_s19.neg ? -signed'({1'b0, sine_s19}) : signed'({1'b0, sine_s19});

	always_ff @(posedge clk) begin
		if (en[ST_MUL]) begin
			aprod_s20 <= signed'({1'b0, pass_s19.astart}) * sine_sg;
			sprod_s20 <= signed'({1'b0, pass_s19.sstart}) * sine_sg;
			pass_s20 <= pass_s19;
		end
	end

	// ---- rounding, size offset, output register
	logic signed [36:0] a_rnd;
	logic signed [50:0] s_rnd;
	logic signed [35:0] size_sum;

	assign a_rnd = 37'(aprod_s20) + 37'sd32768;
	assign s_rnd = 51'(sprod_s20) + 51'sd32768;
	assign size_sum = 36'(signed'(s_rnd[50:16])) + TENTH_Q16;

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			new_pos_x <= pass_s20.nx;
			new_pos_y <= pass_s20.ny;
			new_pos_z <= pass_s20.nz;
			new_vel_y <= pass_s20.nvy;
			new_life_left <= pass_s20.nlife;
			new_alpha <= pass_s20.skip ? 18'sd0 : a_rnd[33:16];
			new_size <= pass_s20.skip ? 32'sd0 : sat32(size_sum);
			skipped <= pass_s20.skip;
		end
	end

	`include "particle_gravity_fade_update_unit_assert.svh"

	`PGFU_ASSERT(a_skip_zero, out_valid && skipped |-> new_alpha == 18'sd0 && new_size == 32'sd0, "skipped word with nonzero alpha or size")
	`PGFU_ASSERT(a_alpha_range, out_valid && !skipped |-> new_alpha <= 18'sd65536 && new_alpha >= -18'sd65536, "alpha out of range")
	`PGFU_NEVER(a_ready_empty_out, !out_valid && !in_ready, "input blocked with empty output stage")
	`PGFU_NEVER(a_div_rem, vld_q[ST_ROM-1] && (rem_sd[DIV_STEPS] >= total_sd[DIV_STEPS]) && !full_sd[DIV_STEPS], "divider remainder not below divisor")

endmodule

FILE: tb/sv/pgfu_checker.sv
// ----------------------------------------------------------------------------
// pgfu_checker
// Watches the particle update unit's channels, predicts each result from the
// accepted particle word and the current gravity setting, and compares.
// ----------------------------------------------------------------------------
module pgfu_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [15:0]        time_step,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	input  logic signed [31:0] life_left,
	input  logic [30:0]        life_total,
	input  logic [16:0]        alpha_start,
	input  logic [30:0]        size_start,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] new_pos_x,
	input  logic signed [31:0] new_pos_y,
	input  logic signed [31:0] new_pos_z,
	input  logic signed [31:0] new_vel_y,
	input  logic signed [31:0] new_life_left,
	input  logic signed [17:0] new_alpha,
	input  logic signed [31:0] new_size,
	input  logic               skipped,
	output int                 fail_count,
	output int                 pending,
	output int                 live_count,
	output int                 dead_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TBITS = 10;

	typedef struct {
		logic signed [31:0] px, py, pz, vy, life;
		logic signed [17:0] alpha;
		logic signed [31:0] size;
		logic               skip;
	} particle_res_t;

	particle_res_t expected_q[$];
	logic [31:0]   gravity;

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// round half up, then arithmetic shift
	function automatic longint rnd_shift(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// quarter-wave sine of k steps, Q16
	function automatic longint sine_q16(input longint unsigned k);
		longint unsigned x, x2, term;
		longint sum, r;
		x = (k * 64'd1686629713 + (64'd1 << (TBITS - 1))) >> TBITS;
		x2 = (x * x + (64'd1 << 29)) >> 30;
		term = x;
		sum = longint'(x);
		for (int n = 1; n <= 10; n++) begin
			term = (term * x2 + (64'd1 << 29)) >> 30;
			term = term / ((2 * n) * (2 * n + 1));
			if (n & 1) sum -= longint'(term);
			else sum += longint'(term);
		end
		if (sum < 0) sum = 0;
		r = (sum + (64'sd1 <<< 13)) >>> 14;
		if (r > 65536) r = 65536;
		return r;
	endfunction

	function automatic particle_res_t predict_particle();
		particle_res_t e;
		longint dt, g, gp, nlife, mag, ratio, s;
		longint unsigned q, k;
		dt = longint'(time_step);
		g = longint'(gravity);
		if (life_left < 0) begin
			e.px = pos_x; e.py = pos_y; e.pz = pos_z; e.vy = vel_y;
			e.life = life_left; e.alpha = '0; e.size = '0; e.skip = 1'b1;
			return e;
		end
		gp = longint'((longint'(dt * dt) * 128'(g) + (128'd1 << 32)) >> 33);
		e.px = 32'(clamp32(longint'(pos_x) + rnd_shift(longint'(vel_x) * dt, 16)));
		e.py = 32'(clamp32(longint'(pos_y) + rnd_shift(longint'(vel_y) * dt, 16) - gp));
		e.pz = 32'(clamp32(longint'(pos_z) + rnd_shift(longint'(vel_z) * dt, 16)));
		e.vy = 32'(clamp32(longint'(vel_y) - ((g * dt + (64'sd1 <<< 15)) >>> 16)));
		nlife = clamp32(longint'(life_left) - dt);
		e.life = 32'(nlife);
		mag = nlife < 0 ? -nlife : nlife;
		if (life_total == 0) ratio = mag != 0 ? 65536 : 0;
		else begin
			q = longint'(mag <<< 16) / longint'(life_total);
			ratio = q > 65536 ? 65536 : q;
		end
		k = (ratio * (64'd1 << TBITS) + (64'd1 << 15)) >> 16;
		s = sine_q16(k);
		if (nlife < 0) s = -s;
		e.alpha = 18'(rnd_shift(longint'(alpha_start) * s, 16));
		e.size = 32'(clamp32(rnd_shift(longint'(size_start) * s, 16) + 6554));
		e.skip = 1'b0;
		return e;
	endfunction

	task automatic report_mismatch(input string field, input longint got, input longint exp);
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, exp, $realtime);
		fail_count++;
	endtask

	// predict on input words, compare on output words
	always @(posedge clk or negedge arst_n) begin
		particle_res_t e;
		if (!arst_n) begin
			gravity <= 32'd1671168;
			fail_count = 0;
			live_count = 0;
			dead_count = 0;
			expected_q.delete();
		end else begin
			if (in_valid && in_ready) begin
				e = predict_particle();
				if (e.skip) dead_count++; else live_count++;
				expected_q.push_back(e);
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected word", 0, 0);
				end else begin
					e = expected_q.pop_front();
					if (new_pos_x !== e.px) report_mismatch("new_pos_x", new_pos_x, e.px);
					if (new_pos_y !== e.py) report_mismatch("new_pos_y", new_pos_y, e.py);
					if (new_pos_z !== e.pz) report_mismatch("new_pos_z", new_pos_z, e.pz);
					if (new_vel_y !== e.vy) report_mismatch("new_vel_y", new_vel_y, e.vy);
					if (new_life_left !== e.life)
						report_mismatch("new_life_left", new_life_left, e.life);
					if (new_alpha !== e.alpha) report_mismatch("new_alpha", new_alpha, e.alpha);
					if (new_size !== e.size) report_mismatch("new_size", new_size, e.size);
					if (skipped !== e.skip) report_mismatch("skipped", skipped, e.skip);
				end
			end
			if (cfg_valid && cfg_ready) gravity <= cfg_data;
		end
		pending = expected_q.size();
	end
endmodule

FILE: tb/sv/tb_particle_gravity_fade_update_unit.sv
// ----------------------------------------------------------------------------
// tb_particle_gravity_fade_update_unit
// Drives directed and random particles through the update unit under several
// gravity settings with random stalls on both sides; a checker compares.
// ----------------------------------------------------------------------------
module tb_particle_gravity_fade_update_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 22;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0, arst_n = 1'b0;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0, in_ready;
	logic [15:0] time_step = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [31:0] vel_x = '0, vel_y = '0, vel_z = '0, life_left = '0;
	logic [30:0] life_total = 31'd1;
	logic [16:0] alpha_start = '0;
	logic [30:0] size_start = '0;
	logic out_valid, out_ready = 1'b0;
	logic signed [31:0] new_pos_x, new_pos_y, new_pos_z, new_vel_y, new_life_left, new_size;
	logic signed [17:0] new_alpha;
	logic skipped;
	int fail_count, pending, live_count, dead_count;
	int idle_cycles;
	bit hold_sink;

	always #4 clk = ~clk;

	particle_gravity_fade_update_unit dut (.*);

	pgfu_checker chk (.*);

	// watchdog: cycles without any accepted word
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_particle_gravity_fade_update_unit: FAIL");
			$finish;
		end
	end
	initial idle_cycles = 0;

	function automatic int gap_len();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
	endfunction

	// output side: random stalls, a long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				out_ready <= 1'b0;
				for (int i = 0; i < 300; i++) @(posedge clk);
				hold_sink = 0;
			end
			out_ready <= 1'b1;
			n = $urandom_range(0, 3) == 0 ? 1 : $urandom_range(1, 30);
			repeat (n) @(posedge clk);
			n = gap_len();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	task automatic write_gravity(input logic [31:0] g);
		cfg_valid <= 1'b1;
		cfg_data <= g;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// one particle word; valid stays up for back-to-back words
	task automatic send_particle(input logic [15:0] dt, input logic signed [31:0] px, py, pz,
			vx, vy, vz, life, input logic [30:0] total, input logic [16:0] a,
			input logic [30:0] sz, input bit gaps);
		int n;
		n = gaps ? gap_len() : 0;
		if ($urandom_range(0, 2) == 0) n = 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		time_step <= dt; pos_x <= px; pos_y <= py; pos_z <= pz;
		vel_x <= vx; vel_y <= vy; vel_z <= vz; life_left <= life;
		life_total <= total; alpha_start <= a; size_start <= sz;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [31:0] rnd_wide();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1: return $urandom_range(0, 200000) - 100000;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_particle(input bit gaps);
		logic signed [31:0] life;
		logic [30:0] total;
		logic [16:0] a;
		case ($urandom_range(0, 9))
			0: life = -$urandom_range(1, 1000000);
			1: life = $urandom_range(0, 1000);
			2: life = rnd_wide();
			default: life = $urandom_range(0, 600000);
		endcase
		case ($urandom_range(0, 7))
			0: total = 0;
			1: total = 31'($urandom >> 1);
			default: total = 31'($urandom_range(1, 700000));
		endcase
		a = $urandom_range(0, 3) == 0 ? 17'd65536 : 17'($urandom_range(0, 65536));
		send_particle($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2000)),
			rnd_wide(), rnd_wide(), rnd_wide(), rnd_wide(), rnd_wide(), rnd_wide(),
			life, total, a, $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 1 << 20)),
			gaps);
	endtask

	initial begin
		logic [31:0] gset[4];
		gset = '{32'd0, 32'hFFFF_FFFF, 32'd1671168, 32'd0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, dead particles, zero total, overflow
		send_particle(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'sd100, 31'd1, 17'd65536, 31'h7FFF_FFFF, 1'b0);
		send_particle(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 17'd0, 31'd0, 1'b0);
		send_particle(16'd0, 32'd5, 32'd6, 32'd7, 32'd1, 32'd2, 32'd3, -32'sd1,
			31'd10, 17'd65536, 31'd65536, 1'b0);
		send_particle(16'd1000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'sd1000,
			31'd0, 17'd65536, 31'h7FFF_FFFF, 1'b0);
		send_particle(16'd1000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'sd10,
			31'd0, 17'd65536, 31'h7FFF_FFFF, 1'b0);
		send_particle(16'd1000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'sd0,
			31'd0, 17'd65536, 31'd65536, 1'b0);
		send_particle(16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'sd0,
			31'd0, 17'd0, 31'd0, 1'b0);
		send_particle(16'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF,
			31'd1, 17'd65536, 31'd65536, 1'b0);
		send_particle(16'd32768, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd65536, 32'd65536,
			32'sd65536, 31'd131072, 17'd65536, 31'd131072, 1'b0);
		for (int i = 0; i < 10; i++) random_particle(1'b0);
		in_valid <= 1'b0;
		drain();

		// random phases under several gravity settings
		for (int p = 0; p < 4; p++) begin
			write_gravity(p == 3 ? $urandom : gset[p]);
			if (p == 1) hold_sink = 1;
			for (int i = 0; i < 180; i++) random_particle(p != 1);
			in_valid <= 1'b0;
			drain();
		end

		$display("covered %0d live and %0d dead particles under the reset gravity and four written",
			live_count, dead_count);
		$display("settings, with stalls on both sides and one long output hold-off");
		if (fail_count == 0)
			$display("tb_particle_gravity_fade_update_unit: PASS");
		else
			$display("tb_particle_gravity_fade_update_unit: FAIL");
		$finish;
	end
endmodule

FILE: files.f
+incdir+sv
sv/pgfu_pkg.sv
sv/particle_gravity_fade_update_unit.sv
tb/sv/pgfu_checker.sv
tb/sv/tb_particle_gravity_fade_update_unit.sv
